>>> hdl/rtu_response_frame_checker_defines.svh
// ----------------------------------------------------------------------------
// rtu response frame checker assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef RTU_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define RTU_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// condition must hold in the same cycle as the trigger, sampled on clk
`define RFC_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger, sampled on clk
`define RFC_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> hdl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// types and constants for the rtu response frame checker
// ----------------------------------------------------------------------------
package rfc_pkg;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_BAD_ADDR  = 3'd2,
        STATUS_CRC_ERR   = 3'd3,
        STATUS_EXCEPTION = 3'd4
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] exception_code;
        logic [7:0] function_code;
    } frame_result_t;

    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [2:0]  COUNT_MAX        = 3'd7;
    localparam logic [2:0]  MIN_FRAME_LEN    = 3'd5;
    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
    localparam int          EXC_FLAG_BIT     = 7;

endpackage

>>> hdl/rfc_crc_step.sv
// ----------------------------------------------------------------------------
// rfc_crc_step
// one byte of reflected crc-16, eight bit steps unrolled
// ----------------------------------------------------------------------------
module rfc_crc_step (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import rfc_pkg::*;

    always_comb
    begin
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

>>> hdl/rfc_frame_track.sv
// ----------------------------------------------------------------------------
// rfc_frame_track
// per-frame state: byte count, delayed crc feed, header bytes, status decision
// ----------------------------------------------------------------------------
module rfc_frame_track (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             rx_byte,
    input  logic                   frame_end,
    input  logic [7:0]             expected_addr,
    output rfc_pkg::frame_result_t result
);
    import rfc_pkg::*;

    logic [2:0]  count_reg,  count_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  older_reg,  older_next;
    logic [7:0]  newer_reg,  newer_next;
    logic [7:0]  addr_reg,   addr_next;
    logic [7:0]  func_reg,   func_next;
    logic [7:0]  third_reg,  third_next;

    logic [15:0] crc_fed;
    logic [15:0] crc_upd;
    logic [2:0]  count_upd;
    logic [7:0]  addr_upd;
    logic [7:0]  func_upd;
    logic [7:0]  third_upd;
    logic [15:0] received;

    rfc_crc_step u_crc_step (
        .crc_in  (crc_reg),
        .data_in (older_reg),
        .crc_out (crc_fed)
    );

    // values as they stand after this byte is taken in
    always_comb
    begin
        addr_upd  = (count_reg == 3'd0) ? rx_byte : addr_reg;
        func_upd  = (count_reg == 3'd1) ? rx_byte : func_reg;
        third_upd = (count_reg == 3'd2) ? rx_byte : third_reg;
        crc_upd   = (count_reg >= 3'd2) ? crc_fed : crc_reg;
        count_upd = (count_reg == COUNT_MAX) ? count_reg : count_reg + 3'd1;
        // last two bytes carry the crc, low byte first
        received  = {rx_byte, newer_reg};
    end

    always_comb
    begin
        result.exception_code = third_upd;
        result.function_code  = func_upd;
        priority if (count_upd < MIN_FRAME_LEN)
        begin
            result.status = STATUS_SHORT;
        end
        else if (addr_upd != expected_addr)
        begin
            result.status = STATUS_BAD_ADDR;
        end
        else if (received != crc_upd)
        begin
            result.status = STATUS_CRC_ERR;
        end
        else if (func_upd[EXC_FLAG_BIT])
        begin
            result.status = STATUS_EXCEPTION;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        addr_next  = addr_reg;
        func_next  = func_reg;
        third_next = third_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                count_next = 3'd0;
                crc_next   = CRC_INIT;
                older_next = 8'h00;
                newer_next = 8'h00;
                addr_next  = 8'h00;
                func_next  = 8'h00;
                third_next = 8'h00;
            end
            else
            begin
                count_next = count_upd;
                crc_next   = crc_upd;
                older_next = newer_reg;
                newer_next = rx_byte;
                addr_next  = addr_upd;
                func_next  = func_upd;
                third_next = third_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            crc_reg   <= CRC_INIT;
            older_reg <= 8'h00;
            newer_reg <= 8'h00;
            addr_reg  <= 8'h00;
            func_reg  <= 8'h00;
            third_reg <= 8'h00;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
            third_reg <= third_next;
        end
    end

endmodule

>>> hdl/rtu_response_frame_checker.sv
// ----------------------------------------------------------------------------
// rtu_response_frame_checker
// checks a received rtu response frame byte by byte and reports one status
// ----------------------------------------------------------------------------
// the status for a frame is registered and appears in the cycle after its last byte is accepted
// throughput: one byte per cycle while in_ready is high, limited by the crc byte update
// in_ready drops only while a finished status waits on out_ready
// reset clears frame state and sets the expected slave address to 1
module rtu_response_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] exception_code,
    output logic [7:0] function_code,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import rfc_pkg::*;

    logic          accept;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    slave_addr_reg, slave_addr_next;
    frame_result_t result;
    frame_result_t result_reg, result_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    rfc_frame_track u_frame_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .expected_addr (slave_addr_reg),
        .result        (result)
    );

    always_comb
    begin
        slave_addr_next = cfg_valid ? cfg_data : slave_addr_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg;
        if (accept && frame_end)
        begin
            result_next    = result;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            slave_addr_reg <= SLAVE_ADDR_RESET;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            slave_addr_reg <= slave_addr_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign exception_code = result_reg.exception_code;
    assign function_code  = result_reg.function_code;

endmodule

>>> hdl/rfc_checker.sv
// ----------------------------------------------------------------------------
// rfc_checker
// port-level assertions for the rtu response frame checker
// ----------------------------------------------------------------------------
`include "rtu_response_frame_checker_defines.svh"

module rfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       frame_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [7:0] exception_code,
    input logic [7:0] function_code
);
    import rfc_pkg::*;

    logic        in_fire;
    logic        end_fire;
    logic        mid_fire;
    logic        out_exc;
    logic        out_ok;
    logic        out_stall;
    logic [18:0] payload;

    assign in_fire   = in_valid && in_ready;
    assign end_fire  = in_fire && frame_end;
    assign mid_fire  = in_fire && !frame_end && !out_valid;
    assign out_exc   = out_valid && (status == STATUS_EXCEPTION);
    assign out_ok    = out_valid && (status == STATUS_OK);
    assign out_stall = out_valid && !out_ready;
    assign payload   = {status, exception_code, function_code};

    // last byte of a frame always yields a status next cycle
    `RFC_ASSERT_NEXT(a_end_gives_status, end_fire, out_valid, "no status after last byte")

    // a mid-frame byte taken while no status is pending never creates a status
    `RFC_ASSERT_NEXT(a_mid_no_status, mid_fire, !out_valid, "status without last byte")

    `RFC_ASSERT_SAME(a_exc_flag, out_exc, function_code[EXC_FLAG_BIT], "exception without flag")

    `RFC_ASSERT_SAME(a_ok_no_flag, out_ok, !function_code[EXC_FLAG_BIT], "ok status with flag")

    // stalled transaction keeps its payload
    `RFC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(payload), "stalled status moved")

endmodule

bind rtu_response_frame_checker rfc_checker u_rfc_checker (.*);
